### rtl/core/reflow_profile_sequencer_assert.svh
// Assertion macros for the reflow profile sequencer
`ifndef REFLOW_PROFILE_SEQUENCER_ASSERT_SVH
`define REFLOW_PROFILE_SEQUENCER_ASSERT_SVH

// check cons in the same cycle as ante
`define RPS_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rps assertion failed");

// check cons in the cycle after ante
`define RPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rps assertion failed");

`endif

### rtl/core/rps_pkg.sv
// Types and constants shared by the reflow profile sequencer modules
package rps_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PREHEAT  = 3'd1,
    PH_SOAK     = 3'd2,
    PH_RAMP     = 3'd3,
    PH_REFLOW   = 3'd4,
    PH_COOL     = 3'd5,
    PH_COMPLETE = 3'd6,
    PH_TOO_HOT  = 3'd7
  } phase_e;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  localparam logic [1:0] GAIN_PREHEAT = 2'd0;
  localparam logic [1:0] GAIN_SOAK    = 2'd1;
  localparam logic [1:0] GAIN_REFLOW  = 2'd2;

  localparam logic [2:0] REG_PREHEAT_TARGET    = 3'd0;
  localparam logic [2:0] REG_SOAK_ENTRY_TEMP   = 3'd1;
  localparam logic [2:0] REG_SOAK_TARGET       = 3'd2;
  localparam logic [2:0] REG_SOAK_TIME_MS      = 3'd3;
  localparam logic [2:0] REG_PEAK_TARGET       = 3'd4;
  localparam logic [2:0] REG_REFLOW_ENTRY_TEMP = 3'd5;
  localparam logic [2:0] REG_REFLOW_TIME_MS    = 3'd6;
  localparam logic [2:0] REG_COOL_TARGET       = 3'd7;

  typedef struct packed {
    logic [11:0] preheat_target;
    logic [11:0] soak_entry_temp;
    logic [11:0] soak_target;
    logic [19:0] soak_time_ms;
    logic [11:0] peak_target;
    logic [11:0] reflow_entry_temp;
    logic [19:0] reflow_time_ms;
    logic [11:0] cool_target;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic        running;
    logic [31:0] stamp;
    logic [11:0] target;
    logic [1:0]  gains;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] temperature;
    logic [31:0] now_ms;
  } item_t;

endpackage

### rtl/core/rps_cfg_regs.sv
// APB register file holding the profile thresholds, targets and time limits
module rps_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output rps_pkg::cfg_t cfg_o
);

  rps_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:2])
        rps_pkg::REG_PREHEAT_TARGET:    cfg_d.preheat_target    = pwdata[11:0];
        rps_pkg::REG_SOAK_ENTRY_TEMP:   cfg_d.soak_entry_temp   = pwdata[11:0];
        rps_pkg::REG_SOAK_TARGET:       cfg_d.soak_target       = pwdata[11:0];
        rps_pkg::REG_SOAK_TIME_MS:      cfg_d.soak_time_ms      = pwdata[19:0];
        rps_pkg::REG_PEAK_TARGET:       cfg_d.peak_target       = pwdata[11:0];
        rps_pkg::REG_REFLOW_ENTRY_TEMP: cfg_d.reflow_entry_temp = pwdata[11:0];
        rps_pkg::REG_REFLOW_TIME_MS:    cfg_d.reflow_time_ms    = pwdata[19:0];
        rps_pkg::REG_COOL_TARGET:       cfg_d.cool_target       = pwdata[11:0];
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      rps_pkg::REG_PREHEAT_TARGET:    prdata = {20'd0, cfg_q.preheat_target};
      rps_pkg::REG_SOAK_ENTRY_TEMP:   prdata = {20'd0, cfg_q.soak_entry_temp};
      rps_pkg::REG_SOAK_TARGET:       prdata = {20'd0, cfg_q.soak_target};
      rps_pkg::REG_SOAK_TIME_MS:      prdata = {12'd0, cfg_q.soak_time_ms};
      rps_pkg::REG_PEAK_TARGET:       prdata = {20'd0, cfg_q.peak_target};
      rps_pkg::REG_REFLOW_ENTRY_TEMP: prdata = {20'd0, cfg_q.reflow_entry_temp};
      rps_pkg::REG_REFLOW_TIME_MS:    prdata = {12'd0, cfg_q.reflow_time_ms};
      rps_pkg::REG_COOL_TARGET:       prdata = {20'd0, cfg_q.cool_target};
      default:                        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preheat_target    <= 12'd600;
      cfg_q.soak_entry_temp   <= 12'd600;
      cfg_q.soak_target       <= 12'd800;
      cfg_q.soak_time_ms      <= 20'd90000;
      cfg_q.peak_target       <= 12'd1000;
      cfg_q.reflow_entry_temp <= 12'd960;
      cfg_q.reflow_time_ms    <= 20'd30000;
      cfg_q.cool_target       <= 12'd400;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/rps_step.sv
// Next-state logic of the profile sequencer for one command or sample
module rps_step #(
  parameter logic [11:0] ROOM_TEMP = 12'd200
) (
  input  rps_pkg::cfg_t   cfg_i,
  input  rps_pkg::state_t state_i,
  input  rps_pkg::item_t  item_i,
  output rps_pkg::state_t state_o,
  output logic            accepted_o
);

  logic [31:0] elapsed;
  logic        soak_done;
  logic        reflow_done;

  assign elapsed     = item_i.now_ms - state_i.stamp;
  assign soak_done   = elapsed > {12'd0, cfg_i.soak_time_ms};
  assign reflow_done = elapsed > {12'd0, cfg_i.reflow_time_ms};

  always_comb begin
    state_o    = state_i;
    accepted_o = 1'b0;
    unique case (item_i.kind)
      rps_pkg::KIND_SAMPLE: begin
        case (state_i.phase)
          rps_pkg::PH_IDLE: begin
            if (state_i.running) begin
              state_o.stamp = item_i.now_ms;
              if (item_i.temperature >= ROOM_TEMP) begin
                state_o.phase = rps_pkg::PH_TOO_HOT;
              end else begin
                state_o.phase  = rps_pkg::PH_PREHEAT;
                state_o.target = cfg_i.preheat_target;
              end
            end
          end
          rps_pkg::PH_PREHEAT: begin
            if (item_i.temperature >= cfg_i.soak_entry_temp) begin
              state_o.phase  = rps_pkg::PH_SOAK;
              state_o.stamp  = item_i.now_ms;
              state_o.gains  = rps_pkg::GAIN_SOAK;
              state_o.target = cfg_i.soak_target;
            end
          end
          rps_pkg::PH_SOAK: begin
            if (soak_done) begin
              state_o.phase  = rps_pkg::PH_RAMP;
              state_o.stamp  = item_i.now_ms;
              state_o.gains  = rps_pkg::GAIN_REFLOW;
              state_o.target = cfg_i.peak_target;
            end
          end
          rps_pkg::PH_RAMP: begin
            if (item_i.temperature >= cfg_i.reflow_entry_temp) begin
              state_o.phase = rps_pkg::PH_REFLOW;
              state_o.stamp = item_i.now_ms;
            end
          end
          rps_pkg::PH_REFLOW: begin
            if (reflow_done) begin
              state_o.phase  = rps_pkg::PH_COOL;
              state_o.stamp  = item_i.now_ms;
              state_o.gains  = rps_pkg::GAIN_REFLOW;
              state_o.target = cfg_i.cool_target;
            end
          end
          rps_pkg::PH_COOL: begin
            if (item_i.temperature <= cfg_i.cool_target) begin
              state_o.phase   = rps_pkg::PH_COMPLETE;
              state_o.stamp   = item_i.now_ms;
              state_o.running = 1'b0;
            end
          end
          rps_pkg::PH_COMPLETE: begin
            state_o.phase = rps_pkg::PH_IDLE;
            state_o.stamp = item_i.now_ms;
          end
          default: begin
            if (item_i.temperature < ROOM_TEMP) begin
              state_o.phase = rps_pkg::PH_IDLE;
              state_o.stamp = item_i.now_ms;
            end
          end
        endcase
      end
      rps_pkg::KIND_START: begin
        if (!state_i.running) begin
          state_o.running = 1'b1;
          accepted_o      = 1'b1;
        end
      end
      rps_pkg::KIND_STOP: begin
        if (state_i.running) begin
          state_o.running = 1'b0;
          state_o.phase   = rps_pkg::PH_IDLE;
          state_o.stamp   = item_i.now_ms;
          accepted_o      = 1'b1;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

### rtl/core/reflow_profile_sequencer.sv
// Top level of the reflow profile sequencer: input register, step logic, result register
//
//   channel   | direction | payload
//   s_axis    | in        | kind in tuser; temperature, now_ms in tdata
//   m_axis    | out       | phase, running, setpoint, gain_set, accepted in tdata
//   apb       | in/out    | eight profile registers at byte address 4*i
//
// One transaction per cycle while the result is not stalled; each passes from input
// to result through the input register, then the step logic into the result register.
// Reset clears the phase state, the run flag and both valid bits and loads
// the register defaults. A stalled result holds the step logic; the input
// register still takes one more transaction if it is empty.
module reflow_profile_sequencer #(
  parameter logic [11:0] ROOM_TEMP = 12'd200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [11:0] temperature, [43:12] now_ms, [47:44] zero
  input  logic [47:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] phase, [3] running, [15:4] setpoint, [17:16] gain_set, [18] accepted,
  // [23:19] zero
  output logic [23:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rps_pkg::cfg_t   cfg;
  rps_pkg::item_t  item_q;
  rps_pkg::state_t state_q, state_d;
  logic            in_valid_q;
  logic            out_valid_q;
  logic [23:0]     out_data_q;
  logic            accepted_d;
  logic            consume;

  rps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rps_step #(
    .ROOM_TEMP (ROOM_TEMP)
  ) u_step (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .item_i     (item_q),
    .state_o    (state_d),
    .accepted_o (accepted_d)
  );

  assign consume         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | consume;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.phase   <= rps_pkg::PH_IDLE;
      state_q.running <= 1'b0;
      state_q.stamp   <= 32'd0;
      state_q.target  <= 12'd0;
      state_q.gains   <= rps_pkg::GAIN_PREHEAT;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (consume) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.kind        <= s_axis_tuser_i;
      item_q.temperature <= s_axis_tdata_i[11:0];
      item_q.now_ms      <= s_axis_tdata_i[43:12];
    end
    if (consume) begin
      out_data_q <= {5'd0, accepted_d, state_d.gains, state_d.target,
                     state_d.running, state_d.phase};
    end
  end

  `include "reflow_profile_sequencer_assert.svh"

  `RPS_ASSERT_NEXT(a_consume_fills_out, consume, out_valid_q)
  `RPS_ASSERT_NEXT(a_state_holds_idle, !consume, $stable(state_q))
  `RPS_ASSERT_SAME(a_gains_legal, 1'b1, state_q.gains != 2'd3)
  `RPS_ASSERT_NEXT(a_input_held, in_valid_q && !consume, in_valid_q)

endmodule
